FILE: rtl/rpa_pkg.sv
// Shared types and constants of the reference-counted page allocator.
`default_nettype none
package rpa_pkg;

  localparam int PAGE_W   = 15;
  localparam int REF_W    = 8;
  localparam int STATUS_W = 3;
  localparam int OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_ADDREF = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_OOM    = 3'd1,
    ST_DOUBLE = 3'd2,
    ST_RANGE  = 3'd3,
    ST_SAT    = 3'd4
  } status_e;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    op_e               op;
    logic [PAGE_W-1:0] page;
    logic              in_range;
  } item_t;

  // Queue control between front end, queue and back end.
  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // One result as the back end delivers it.
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] alloc_page;
    status_e           status;
    logic [REF_W-1:0]  ref_after;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/rpa_front.sv
// Front end: accepts items and classifies them (operation decode, range check).
`default_nettype none
module rpa_front #(
  parameter int NUM_PAGES = 32768
) (
  input  wire logic                         start_i,
  input  wire logic                         busy_i,
  input  wire logic [rpa_pkg::OP_W-1:0]     operation_i,
  input  wire logic [rpa_pkg::PAGE_W-1:0]   page_i,
  input  wire logic [rpa_pkg::PAGE_W-1:0]   first_page_i,
  output rpa_pkg::push_t                    push_o
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int WW = ((AW > rpa_pkg::PAGE_W) ? AW : rpa_pkg::PAGE_W) + 1;
  localparam logic [WW-1:0] NP = WW'(NUM_PAGES);

  logic [WW-1:0] page_ext;
  logic [WW-1:0] first_ext;

  assign page_ext  = WW'(page_i);
  assign first_ext = WW'(first_page_i);

  always_comb begin
    push_o.push          = start_i & ~busy_i;
    push_o.item.op       = rpa_pkg::op_e'(operation_i);
    push_o.item.page     = page_i;
    push_o.item.in_range = (page_ext >= first_ext) && (page_ext < NP);
  end

endmodule
`default_nettype wire

FILE: rtl/rpa_queue.sv
// Two-entry queue of classified items between front end and back end.
`default_nettype none
module rpa_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rpa_pkg::push_t push_i,
  input  wire logic           pop_i,
  output rpa_pkg::item_t      head_o,
  output rpa_pkg::queue_stat_t stat_o
);

  rpa_pkg::item_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i.push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i.push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      entry_q[wr_ptr_q] <= push_i.item;
    end
  end

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule
`default_nettype wire

FILE: rtl/rpa_back.sv
// Back end: free-page stack and count memories, clearing pass and execution.
`default_nettype none
module rpa_back #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       restart_i,
  input  wire logic [rpa_pkg::PAGE_W-1:0] first_page_i,
  input  wire rpa_pkg::item_t             head_i,
  input  wire rpa_pkg::queue_stat_t       queue_i,
  output logic                            pop_o,
  output logic                            clearing_o,
  output rpa_pkg::result_t                result_o
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int WW = ((AW > rpa_pkg::PAGE_W) ? AW : rpa_pkg::PAGE_W) + 1;
  localparam int OW = (COUNT_BITS > rpa_pkg::REF_W) ? COUNT_BITS : rpa_pkg::REF_W;
  localparam logic [WW-1:0]         NP_W     = WW'(NUM_PAGES);
  localparam logic [AW:0]           NP_D     = (AW+1)'(NUM_PAGES);
  localparam logic [AW-1:0]         LAST_IDX = AW'(NUM_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CMAX     = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CONE     = COUNT_BITS'(1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_WAIT  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW:0]   depth_q, depth_d;
  rpa_pkg::item_t cur_q;
  rpa_pkg::result_t res_q, res_d;

  logic [COUNT_BITS-1:0] cmem [NUM_PAGES];
  logic [AW-1:0]         smem [NUM_PAGES];
  logic [COUNT_BITS-1:0] crd_q;
  logic [AW-1:0]         srd_q;

  logic                  cwe, swe;
  logic [AW-1:0]         cwa, cra, swa, sra;
  logic [COUNT_BITS-1:0] cwd;
  logic [AW-1:0]         swd;

  logic [WW-1:0] first_ext, head_ext, cur_ext, fill_sum, apage_ext;
  logic [AW:0]   init_depth;
  logic [COUNT_BITS-1:0] after;
  logic [OW-1:0] after_ext;

  assign first_ext  = WW'(first_page_i);
  assign head_ext   = WW'(head_i.page);
  assign cur_ext    = WW'(cur_q.page);
  assign fill_sum   = first_ext + WW'(cnt_q);
  assign apage_ext  = WW'(srd_q);
  assign init_depth = (first_ext >= NP_W) ? '0 : (AW+1)'(NP_W - first_ext);

  assign pop_o      = (state_q == S_WAIT) && !queue_i.empty;
  assign clearing_o = (state_q == S_CLEAR);
  assign cra        = head_ext[AW-1:0];
  assign sra        = AW'(depth_q - (AW+1)'(1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    depth_d   = depth_q;
    cwe       = 1'b0;
    cwa       = cur_ext[AW-1:0];
    cwd       = '0;
    swe       = 1'b0;
    swa       = depth_q[AW-1:0];
    swd       = cur_ext[AW-1:0];
    after     = '0;
    after_ext = '0;
    res_d     = '0;

    case (state_q)
      S_CLEAR: begin
        // Sweep both memories: counts to zero, stack to the ascending page run.
        cwe   = 1'b1;
        cwa   = cnt_q;
        swe   = 1'b1;
        swa   = cnt_q;
        swd   = fill_sum[AW-1:0];
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = S_WAIT;
          depth_d = init_depth;
        end
      end
      S_WAIT: begin
        if (!queue_i.empty) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d      = S_WAIT;
        res_d.valid  = 1'b1;
        res_d.status = rpa_pkg::ST_OK;
        case (cur_q.op)
          rpa_pkg::OP_ALLOC: begin
            if (depth_q == '0) begin
              res_d.status = rpa_pkg::ST_OOM;
            end else begin
              depth_d          = depth_q - (AW+1)'(1);
              cwe              = 1'b1;
              cwa              = srd_q;
              cwd              = CONE;
              after            = CONE;
              res_d.alloc_page = apage_ext[rpa_pkg::PAGE_W-1:0];
            end
          end
          rpa_pkg::OP_FREE: begin
            if (!cur_q.in_range) begin
              res_d.status = rpa_pkg::ST_RANGE;
            end else if (crd_q > CONE) begin
              cwe   = 1'b1;
              cwd   = crd_q - CONE;
              after = crd_q - CONE;
            end else if (crd_q == CONE) begin
              cwe = 1'b1;
              cwd = '0;
              // A push onto a full stack is dropped.
              if (depth_q < NP_D) begin
                swe     = 1'b1;
                depth_d = depth_q + (AW+1)'(1);
              end
            end else begin
              res_d.status = rpa_pkg::ST_DOUBLE;
            end
          end
          rpa_pkg::OP_ADDREF: begin
            if (!cur_q.in_range) begin
              res_d.status = rpa_pkg::ST_RANGE;
            end else if (crd_q == CMAX) begin
              res_d.status = rpa_pkg::ST_SAT;
              after        = CMAX;
            end else begin
              cwe   = 1'b1;
              cwd   = crd_q + CONE;
              after = crd_q + CONE;
            end
          end
          default: begin
            res_d.status = rpa_pkg::ST_OK;
          end
        endcase
        after_ext       = OW'(after);
        res_d.ref_after = after_ext[rpa_pkg::REF_W-1:0];
      end
      default: begin
        state_d = S_CLEAR;
        cnt_d   = '0;
      end
    endcase

    if (restart_i) begin
      state_d = S_CLEAR;
      cnt_d   = '0;
      depth_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      depth_q <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      depth_q <= depth_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cwe) begin
      cmem[cwa] <= cwd;
    end
    crd_q <= cmem[cra];
  end

  always_ff @(posedge clk_i) begin
    if (swe) begin
      smem[swa] <= swd;
    end
    srd_q <= smem[sra];
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

FILE: rtl/refcounted_page_allocator.sv
// Top level of the reference-counted page allocator.
//
//   channel   handshake                      payload
//   command   start_i / busy_o               operation_i, page_i
//   result    done_o (one-cycle strobe)      alloc_page_o, status_o, ref_after_o
//   config    first_free_page_we_i           first_free_page_i
//
// The back end handles one item at a time: in S_WAIT it pops the item and reads
// the count and stack memories, in S_EXEC it writes them back and registers the
// result. An accepted item passes through the queue entry and the item register
// before the result register raises done_o. After reset and after every write
// of first_free_page the block runs a clearing pass with busy_o high.
// busy_o is also high while the two-entry item queue is full; results are never
// held back.
`default_nettype none
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [rpa_pkg::OP_W-1:0]      operation_i,
  input  wire logic [rpa_pkg::PAGE_W-1:0]    page_i,
  input  wire logic                          first_free_page_we_i,
  input  wire logic [rpa_pkg::PAGE_W-1:0]    first_free_page_i,
  output logic                               done_o,
  output logic [rpa_pkg::PAGE_W-1:0]         alloc_page_o,
  output logic [rpa_pkg::STATUS_W-1:0]       status_o,
  output logic [rpa_pkg::REF_W-1:0]          ref_after_o
);

  logic [rpa_pkg::PAGE_W-1:0] first_q;
  rpa_pkg::push_t       push;
  rpa_pkg::item_t       head;
  rpa_pkg::queue_stat_t qstat;
  rpa_pkg::result_t     result;
  logic                 pop;
  logic                 clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
    end else if (first_free_page_we_i) begin
      first_q <= first_free_page_i;
    end
  end

  assign busy_o = clearing | qstat.full;

  rpa_front #(
    .NUM_PAGES (NUM_PAGES)
  ) u_front (
    .start_i      (start_i),
    .busy_i       (busy_o),
    .operation_i  (operation_i),
    .page_i       (page_i),
    .first_page_i (first_q),
    .push_o       (push)
  );

  rpa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  rpa_back #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (first_free_page_we_i),
    .first_page_i (first_q),
    .head_i       (head),
    .queue_i      (qstat),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .result_o     (result)
  );

  assign done_o       = result.valid;
  assign alloc_page_o = result.alloc_page;
  assign status_o     = result.status;
  assign ref_after_o  = result.ref_after;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the reference-counted page allocator.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_PAGES   = 32768;
  localparam int COUNT_BITS  = 8;
  localparam int PAGE_W      = rpa_pkg::PAGE_W;
  localparam int REF_W       = rpa_pkg::REF_W;
  localparam int OP_W        = rpa_pkg::OP_W;
  localparam int STATUS_W    = rpa_pkg::STATUS_W;
  localparam logic [REF_W-1:0] COUNT_MAX = REF_W'((1 << COUNT_BITS) - 1);
  localparam logic [REF_W-1:0] COUNT_ONE = REF_W'(1);
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    rpa_pkg::op_e      op;
    logic [PAGE_W-1:0] page;
  } page_cmd_t;

  typedef struct {
    logic [PAGE_W-1:0] alloc_page;
    rpa_pkg::status_e  status;
    logic [REF_W-1:0]  ref_after;
  } alloc_outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_n_r = 1'b0;
  logic                start_r = 1'b0;
  logic [OP_W-1:0]     op_r = '0;
  logic [PAGE_W-1:0]   page_r = '0;
  logic                cfg_we_r = 1'b0;
  logic [PAGE_W-1:0]   cfg_data_r = '0;
  logic                busy_o;
  logic                done_o;
  logic [PAGE_W-1:0]   alloc_page_o;
  logic [STATUS_W-1:0] status_o;
  logic [REF_W-1:0]    ref_after_o;

  page_cmd_t      pending_cmds[$];
  alloc_outcome_t awaited_outcomes[$];
  page_cmd_t      next_cmd;
  alloc_outcome_t seen_outcome;
  int             sender_idle_pct = 0;
  int             mismatch_count = 0;
  int             cycle_count = 0;

  // Shadow allocator state.
  logic [PAGE_W-1:0] first_page;
  logic [REF_W-1:0]  page_counts[NUM_PAGES];
  logic [PAGE_W-1:0] free_pages[NUM_PAGES];
  int                free_depth;

  refcounted_page_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_n_r),
    .start_i             (start_r),
    .busy_o              (busy_o),
    .operation_i         (op_r),
    .page_i              (page_r),
    .first_free_page_we_i(cfg_we_r),
    .first_free_page_i   (cfg_data_r),
    .done_o              (done_o),
    .alloc_page_o        (alloc_page_o),
    .status_o            (status_o),
    .ref_after_o         (ref_after_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void refill_free_pages();
    for (int p = 0; p < NUM_PAGES; p++) begin
      page_counts[p] = '0;
    end
    free_depth = 0;
    for (int p = int'(first_page); p < NUM_PAGES; p++) begin
      free_pages[free_depth] = p[PAGE_W-1:0];
      free_depth++;
    end
  endfunction

  function automatic alloc_outcome_t apply_page_op(rpa_pkg::op_e op,
                                                   logic [PAGE_W-1:0] pg);
    alloc_outcome_t   r;
    logic [REF_W-1:0] cnt;
    r.alloc_page = '0;
    r.status     = rpa_pkg::ST_OK;
    r.ref_after  = '0;
    cnt          = page_counts[pg];
    case (op)
      rpa_pkg::OP_ALLOC: begin
        if (free_depth == 0) begin
          r.status = rpa_pkg::ST_OOM;
        end else begin
          free_depth--;
          r.alloc_page = free_pages[free_depth];
          page_counts[r.alloc_page] = COUNT_ONE;
          r.ref_after = COUNT_ONE;
        end
      end
      rpa_pkg::OP_FREE: begin
        if (pg < first_page) begin
          r.status = rpa_pkg::ST_RANGE;
        end else if (cnt > COUNT_ONE) begin
          page_counts[pg] = cnt - COUNT_ONE;
          r.ref_after = cnt - COUNT_ONE;
        end else if (cnt == COUNT_ONE) begin
          page_counts[pg] = '0;
          // A push onto a full stack is lost.
          if (free_depth < NUM_PAGES) begin
            free_pages[free_depth] = pg;
            free_depth++;
          end
        end else begin
          r.status = rpa_pkg::ST_DOUBLE;
        end
      end
      rpa_pkg::OP_ADDREF: begin
        if (pg < first_page) begin
          r.status = rpa_pkg::ST_RANGE;
        end else if (cnt == COUNT_MAX) begin
          r.status = rpa_pkg::ST_SAT;
          r.ref_after = COUNT_MAX;
        end else begin
          page_counts[pg] = cnt + COUNT_ONE;
          r.ref_after = cnt + COUNT_ONE;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Driver: presents queued items, holding each one until busy_o is low.
  always @(posedge clk_i) begin
    if (!rst_n_r) begin
      start_r <= 1'b0;
    end else begin
      if (start_r && !busy_o) begin
        awaited_outcomes.push_back(apply_page_op(rpa_pkg::op_e'(op_r), page_r));
      end
      if (!start_r || !busy_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          start_r <= 1'b1;
          op_r    <= next_cmd.op;
          page_r  <= next_cmd.page;
        end else begin
          start_r <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done_o strobe is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_n_r && done_o) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        seen_outcome = awaited_outcomes.pop_front();
        if (alloc_page_o !== seen_outcome.alloc_page) begin
          report_mismatch($sformatf("alloc_page %0d, predicted %0d",
                                    alloc_page_o, seen_outcome.alloc_page));
        end
        if (status_o !== seen_outcome.status) begin
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    status_o, seen_outcome.status));
        end
        if (ref_after_o !== seen_outcome.ref_after) begin
          report_mismatch($sformatf("ref_after %0d, predicted %0d",
                                    ref_after_o, seen_outcome.ref_after));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_cmd(rpa_pkg::op_e op, logic [PAGE_W-1:0] pg);
    page_cmd_t c;
    c.op   = op;
    c.page = pg;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || awaited_outcomes.size() != 0 || start_r) begin
      @(negedge clk_i);
    end
  endtask

  // Writing first_free_page restarts the clearing pass, so only do it when idle.
  task automatic write_first_page(logic [PAGE_W-1:0] value);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_r   <= 1'b1;
    cfg_data_r <= value;
    @(posedge clk_i);
    cfg_we_r   <= 1'b0;
    first_page = value;
    refill_free_pages();
    repeat (4) @(posedge clk_i);
  endtask

  // Pages are drawn mostly from the top of the range, where the stack hands
  // them out, so frees and add references usually hit live pages.
  task automatic queue_random_mix(int count);
    int                r;
    int                lo;
    rpa_pkg::op_e      op;
    logic [PAGE_W-1:0] pg;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 36) op = rpa_pkg::OP_ALLOC;
      else if (r < 70) op = rpa_pkg::OP_FREE;
      else if (r < 94) op = rpa_pkg::OP_ADDREF;
      else op = rpa_pkg::OP_NOP;
      lo = (int'(first_page) > NUM_PAGES - 24) ? int'(first_page) : NUM_PAGES - 24;
      r = $urandom_range(99);
      if (r < 75) pg = PAGE_W'($urandom_range(NUM_PAGES - 1, lo));
      else if (r < 80 && first_page != '0) pg = first_page - PAGE_W'(1);
      else if (r < 88 && first_page != '0) begin
        pg = PAGE_W'($urandom_range(int'(first_page) - 1, 0));
      end
      else pg = PAGE_W'($urandom());
      queue_cmd(op, pg);
    end
  endtask

  initial begin
    first_page = '0;
    refill_free_pages();
    repeat (10) @(posedge clk_i);
    rst_n_r <= 1'b1;

    // Full range: add reference on a free page, then free it onto a full stack.
    queue_cmd(rpa_pkg::OP_ADDREF, 15'd100);
    queue_cmd(rpa_pkg::OP_FREE, 15'd100);
    queue_cmd(rpa_pkg::OP_FREE, 15'd100);
    queue_cmd(rpa_pkg::OP_ALLOC, 15'h5A5A);
    queue_cmd(rpa_pkg::OP_ADDREF, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_FREE, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_FREE, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_NOP, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_NOP, 15'd0);
    queue_cmd(rpa_pkg::OP_ADDREF, 15'd0);
    queue_cmd(rpa_pkg::OP_FREE, 15'd0);
    queue_cmd(rpa_pkg::OP_ALLOC, 15'd0);

    // A single managed page: out of range below it and out of memory.
    write_first_page(15'h7FFF);
    queue_cmd(rpa_pkg::OP_FREE, 15'd0);
    queue_cmd(rpa_pkg::OP_ADDREF, 15'h7FFE);
    queue_cmd(rpa_pkg::OP_ALLOC, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_ALLOC, 15'd0);
    queue_cmd(rpa_pkg::OP_ADDREF, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_FREE, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_FREE, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_FREE, 15'h7FFF);
    queue_cmd(rpa_pkg::OP_ALLOC, 15'h2AAA);
    queue_cmd(rpa_pkg::OP_NOP, 15'h5555);

    // Eight pages, sender never idle; the stack runs dry often.
    write_first_page(15'(NUM_PAGES - 8));
    sender_idle_pct = 0;
    queue_random_mix(250);
    wait_drained();
    queue_random_mix(250);

    // Full range with a sparse sender, including a run to saturation and back.
    write_first_page(15'd0);
    sender_idle_pct = 83;
    queue_random_mix(200);
    for (int i = 0; i < 258; i++) queue_cmd(rpa_pkg::OP_ADDREF, 15'h7FFF);
    for (int i = 0; i < 260; i++) queue_cmd(rpa_pkg::OP_FREE, 15'h7FFF);
    queue_random_mix(200);

    write_first_page(15'($urandom_range(NUM_PAGES - 1, 1)));
    sender_idle_pct = 17;
    queue_random_mix(600);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
